>>> hw/rtl/dd_pkg.sv
package dd_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned ResultW = 23;
  // Shifted year (year + 400) and its derived quotients
  localparam int unsigned YyW     = 15;
  localparam int unsigned Q4W     = YyW - 2;
  localparam int unsigned QW      = 8;
  // Day number, unsigned; largest value stays below 2**23
  localparam int unsigned DayNumW = 23;
  // Reciprocal of 25 as 5243 / 2**17, exact for dividends below 4196
  localparam int unsigned Recip25      = 5243;
  localparam int unsigned Recip25Shift = 17;
  localparam int unsigned MagLimit     = 4194303;

  typedef struct packed {
    logic [YearW-1:0]  year_a;
    logic [MonthW-1:0] month_a;
    logic [DayW-1:0]   day_a;
    logic [YearW-1:0]  year_b;
    logic [MonthW-1:0] month_b;
    logic [DayW-1:0]   day_b;
    logic              include_end;
  } dd_req_t;

  typedef struct packed {
    logic signed [ResultW-1:0] day_difference;
    logic                      date_error;
  } dd_rsp_t;

  // What one lane hands to the merge stage
  typedef struct packed {
    logic               ok;
    logic [DayNumW-1:0] day_num;
  } dd_lane_t;

  // Length of a month in a common year; zero for month codes outside 1..12
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days before the month in a year counted from March: (153*mp + 2) / 5
  function automatic logic [8:0] month_offset(input logic [MonthW-1:0] m);
    logic [8:0] off;
    case (m)
      4'd3:    off = 9'd0;
      4'd4:    off = 9'd31;
      4'd5:    off = 9'd61;
      4'd6:    off = 9'd92;
      4'd7:    off = 9'd122;
      4'd8:    off = 9'd153;
      4'd9:    off = 9'd184;
      4'd10:   off = 9'd214;
      4'd11:   off = 9'd245;
      4'd12:   off = 9'd275;
      4'd1:    off = 9'd306;
      4'd2:    off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

>>> hw/rtl/dd_lane.sv
module dd_lane
  import dd_pkg::*;
(
  input  logic              clk_i,
  input  logic [YearW-1:0]  year_i,
  input  logic [MonthW-1:0] month_i,
  input  logic [DayW-1:0]   day_i,
  output dd_lane_t          lane_o
);

  // Stage 1: shifted year and the divisions by 100
  logic [YyW-1:0]    yy_d, yy_q;
  logic [QW-1:0]     q100_d, q100_q;
  logic [QW-1:0]     qy_d, qy_q;
  logic [YearW-1:0]  year_q;
  logic [MonthW-1:0] month_q;
  logic [DayW-1:0]   day_q;

  logic              early_month;
  logic [Q4W-1:0]    q4yy;
  logic [YearW-3:0]  q4y;
  logic [Q4W+13:0]   prod_yy;
  logic [YearW+11:0] prod_y;

  always_comb begin
    early_month = (month_i <= MonthW'(2));
    yy_d  = YyW'(year_i) + YyW'(400) - YyW'(early_month);
    q4yy  = yy_d[YyW-1:2];
    q4y   = year_i[YearW-1:2];
    prod_yy = (Q4W+14)'(q4yy) * (Q4W+14)'(Recip25);
    prod_y  = (YearW+12)'(q4y) * (YearW+12)'(Recip25);
    q100_d = QW'(prod_yy >> Recip25Shift);
    qy_d   = QW'(prod_y >> Recip25Shift);
  end

  always_ff @(posedge clk_i) begin
    yy_q    <= yy_d;
    q100_q  <= q100_d;
    qy_q    <= qy_d;
    year_q  <= year_i;
    month_q <= month_i;
    day_q   <= day_i;
  end

  // Stage 2: leap test, range check and the day number sum
  logic [YearW-3:0]   rem25;
  logic               leap;
  logic [DayW-1:0]    len;
  logic               ok_d;
  logic [DayNumW:0]   sum;
  dd_lane_t           lane_q;

  always_comb begin
    rem25 = year_q[YearW-1:2] - ((YearW-2)'(qy_q) * (YearW-2)'(25));
    leap  = (year_q[1:0] == 2'd0) && ((rem25 != '0) || (qy_q[1:0] == 2'd0));
    len   = month_len(month_q);
    if (month_q == MonthW'(2) && leap) begin
      len = DayW'(29);
    end
    ok_d = (len != '0) && (day_q != '0) && (day_q <= len);
    sum  = (DayNumW+1)'(yy_q) * (DayNumW+1)'(365)
         + (DayNumW+1)'(yy_q[YyW-1:2])
         - (DayNumW+1)'(q100_q)
         + (DayNumW+1)'(q100_q[QW-1:2])
         + (DayNumW+1)'(month_offset(month_q))
         + (DayNumW+1)'(day_q);
  end

  always_ff @(posedge clk_i) begin
    lane_q.ok      <= ok_d;
    lane_q.day_num <= sum[DayNumW-1:0];
  end

  assign lane_o = lane_q;

endmodule

>>> hw/rtl/dd_merge.sv
module dd_merge
  import dd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  logic     include_end_i,
  input  dd_lane_t lane_a_i,
  input  dd_lane_t lane_b_i,
  output logic     done_o,
  output dd_rsp_t  rsp_o
);

  logic               a_before_b;
  logic [DayNumW-1:0] mag;
  logic [DayNumW:0]   mag_inc;
  logic [DayNumW-1:0] mag_sat;
  logic [ResultW-1:0] res;
  dd_rsp_t            rsp_d, rsp_q;
  logic               done_q;

  always_comb begin
    a_before_b = lane_a_i.day_num < lane_b_i.day_num;
    mag = a_before_b ? (lane_b_i.day_num - lane_a_i.day_num)
                     : (lane_a_i.day_num - lane_b_i.day_num);
    mag_inc = (DayNumW+1)'(mag) + (DayNumW+1)'(include_end_i);
    mag_sat = (mag_inc > (DayNumW+1)'(MagLimit)) ? DayNumW'(MagLimit)
                                                 : mag_inc[DayNumW-1:0];
    res = a_before_b ? ResultW'(mag_sat) : ResultW'(-mag_sat);
    if (lane_a_i.ok && lane_b_i.ok) begin
      rsp_d.day_difference = res;
      rsp_d.date_error     = 1'b0;
    end else begin
      rsp_d.day_difference = '0;
      rsp_d.date_error     = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

>>> hw/rtl/date_difference_days.sv
// Channel   | Ports            | Handshake
// ----------+------------------+---------------------------------------------
// request   | start, req_i     | taken on a rising edge with start high and
//           |                  | busy low
// result    | done_o, rsp_o    | done_o marks one cycle; taken on the edge
//           |                  | that ends it, no back-pressure
//
// A request passes through the two lane stages (divide by 100, then the day
// number sum) and then the merge register on its way to the result. One
// request may enter on every cycle, so up to three are in flight at once.
// rst_ni clears the valid pipeline and the result strobe at once.
// The receiver cannot stall, so busy never rises.
module date_difference_days
  import dd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  dd_req_t req_i,
  output logic    done_o,
  output dd_rsp_t rsp_o
);

  // Accept whenever start is high; every stage advances every cycle
  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Valid bits follow each request through the two lane stages
  logic [1:0] valid_d, valid_q;
  assign valid_d = {valid_q[0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Carry include_end alongside the lanes; no reset needed on payload
  logic [1:0] inc_d, inc_q;
  assign inc_d = {inc_q[0], req_i.include_end};

  always_ff @(posedge clk_i) begin
    inc_q <= inc_d;
  end

  // One lane per date; both run the same day number core in parallel
  dd_lane_t lane_a, lane_b;

  dd_lane u_lane_a (
    .clk_i   (clk_i),
    .year_i  (req_i.year_a),
    .month_i (req_i.month_a),
    .day_i   (req_i.day_a),
    .lane_o  (lane_a)
  );

  dd_lane u_lane_b (
    .clk_i   (clk_i),
    .year_i  (req_i.year_b),
    .month_i (req_i.month_b),
    .day_i   (req_i.day_b),
    .lane_o  (lane_b)
  );

  // Subtract, add the end day, saturate and sign the result, or flag a date error
  dd_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (valid_q[1]),
    .include_end_i (inc_q[1]),
    .lane_a_i      (lane_a),
    .lane_b_i      (lane_b),
    .done_o        (done_o),
    .rsp_o         (rsp_o)
  );

endmodule

>>> hw/rtl/dd_checker.sv
module dd_checker
  import dd_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start,
  input logic    busy,
  input logic    done_o,
  input dd_rsp_t rsp_o
);

  // Each result must come from an accepted request that has passed through the pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 3))
    else $error("result without a request three cycles earlier");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(start && !busy, 3) && $past(rst_ni, 3) && $past(rst_ni, 2)
     && $past(rst_ni, 1)) |-> done_o)
    else $error("request dropped");

  // An invalid date gives a zero difference
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.date_error) |-> (rsp_o.day_difference == '0))
    else $error("nonzero difference with date error");

  // Saturation keeps the result away from the most negative code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.day_difference != {1'b1, {(ResultW-1){1'b0}}}))
    else $error("difference outside the saturated range");

endmodule

bind date_difference_days dd_checker u_dd_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);

>>> tb/testbench.sv
module testbench
  import dd_pkg::*;
();

  // Clock period and bounds on the run
  localparam int unsigned ClkPeriod   = 8;
  localparam int unsigned ResetCycles = 6;
  localparam int unsigned TailCycles  = 8;       // pipeline is three deep
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomReqs  = 1330;
  localparam int unsigned DrainEvery  = 250;
  localparam int unsigned ShowLimit   = 10;

  // Largest magnitude the result field can carry
  localparam int unsigned SatLimit = 4194303;

  // Month lengths of a common year, January first
  localparam int unsigned MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  // One entry of the stimulus queue: either a request to send, or a marker
  // telling the driver to hold off until every owed result has come back.
  typedef struct {
    dd_req_t req;
    bit      drain;
  } pending_t;

  logic    clk_i  = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start  = 1'b0;
  logic    busy;
  dd_req_t req    = '0;
  logic    done;
  dd_rsp_t rsp;

  pending_t    pending_reqs [$];
  dd_rsp_t     expected_diffs [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  date_difference_days u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req),
    .done_o (done),
    .rsp_o  (rsp)
  );

  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Calendar arithmetic for the predictor
  // ---------------------------------------------------------------------

  function automatic bit is_leap(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Length of month m of year y; zero for a month code outside 1..12
  function automatic int unsigned month_span(int unsigned y, int unsigned m);
    if (m < 1 || m > 12) return 0;
    if (m == 2) return is_leap(y) ? 29 : 28;
    return MonthDays[m-1];
  endfunction

  function automatic bit date_ok(int unsigned y, int unsigned m, int unsigned d);
    return (d >= 1) && (d <= month_span(y, m));
  endfunction

  // Count days from a fixed origin. Shift the year by 400 so the value stays
  // positive for year zero, and start the year in March so that the leap day
  // falls at its end; both offsets cancel in a difference.
  function automatic int unsigned day_count(int unsigned y, int unsigned m, int unsigned d);
    int unsigned yy;
    int unsigned mp;
    yy = y + 400;
    if (m <= 2) yy = yy - 1;
    mp = (m + 9) % 12;
    return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * mp + 2) / 5 + d;
  endfunction

  // Signed days from date a to date b. The sign is negative whenever a is
  // not strictly before b; include_end widens the magnitude by one before the
  // sign goes on, and the magnitude saturates at the field's limit.
  function automatic dd_rsp_t days_between(dd_req_t r);
    dd_rsp_t     res;
    int unsigned na;
    int unsigned nb;
    int unsigned mag;
    bit          neg;
    res = '0;
    if (!date_ok(r.year_a, r.month_a, r.day_a) || !date_ok(r.year_b, r.month_b, r.day_b)) begin
      res.date_error = 1'b1;
      return res;
    end
    na = day_count(r.year_a, r.month_a, r.day_a);
    nb = day_count(r.year_b, r.month_b, r.day_b);
    if (na < nb) begin
      mag = nb - na;
      neg = 1'b0;
    end else begin
      mag = na - nb;
      neg = 1'b1;
    end
    mag = mag + r.include_end;
    if (mag > SatLimit) mag = SatLimit;
    res.day_difference = neg ? ResultW'(0 - mag) : ResultW'(mag);
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  task automatic add_request(int unsigned ya, int unsigned ma, int unsigned da,
                             int unsigned yb, int unsigned mb, int unsigned db,
                             bit inc);
    pending_t p;
    p.drain           = 1'b0;
    p.req.year_a      = YearW'(ya);
    p.req.month_a     = MonthW'(ma);
    p.req.day_a       = DayW'(da);
    p.req.year_b      = YearW'(yb);
    p.req.month_b     = MonthW'(mb);
    p.req.day_b       = DayW'(db);
    p.req.include_end = inc;
    pending_reqs.push_back(p);
  endtask

  task automatic add_drain();
    pending_t p;
    p.req   = '0;
    p.drain = 1'b1;
    pending_reqs.push_back(p);
  endtask

  // Pick a valid date; the wide flag lets the year roam the whole field,
  // year zero and the years past 9999 included.
  task automatic pick_date(input bit wide, output int unsigned y,
                           output int unsigned m, output int unsigned d);
    y = wide ? $urandom_range(0, (1 << YearW) - 1) : $urandom_range(1, 9999);
    m = $urandom_range(1, 12);
    d = $urandom_range(1, month_span(y, m));
  endtask

  task automatic add_random_request();
    int unsigned ya, ma, da, yb, mb, db;
    int unsigned kind;
    pick_date($urandom_range(0, 9) == 0, ya, ma, da);
    pick_date($urandom_range(0, 9) == 0, yb, mb, db);
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      // Equal dates
      yb = ya;
      mb = ma;
      db = da;
    end else if (kind < 35) begin
      // Nearby dates: same year, or one year apart
      yb = (kind < 25) ? ya : ya + 1;
      mb = $urandom_range(1, 12);
      db = $urandom_range(1, month_span(yb, mb));
    end else if (kind < 55) begin
      // Possibly corrupt one or both dates with raw field values
      if ($urandom_range(0, 1)) ma = $urandom_range(0, 15);
      if ($urandom_range(0, 1)) da = $urandom_range(0, 31);
      if ($urandom_range(0, 2) == 0) mb = $urandom_range(0, 15);
      if ($urandom_range(0, 2) == 0) db = $urandom_range(0, 31);
      if (kind < 40) ya = $urandom_range(0, (1 << YearW) - 1);
    end
    add_request(ya, ma, da, yb, mb, db, $urandom_range(0, 1));
  endtask

  // ---------------------------------------------------------------------
  // Driver: present queued requests in bursts with random gaps
  // ---------------------------------------------------------------------

  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin : driver
    pending_t p;
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      // Whatever was presented has been taken; choose what comes next.
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        start <= 1'b0;
      end else if (pending_reqs.size() == 0) begin
        start <= 1'b0;
      end else if (pending_reqs[0].drain) begin
        // Hold off until the pipeline is empty. With start low and no result
        // on the ports this edge, the expectation store cannot change here.
        start <= 1'b0;
        if (!start && !done && expected_diffs.size() == 0) void'(pending_reqs.pop_front());
      end else begin
        p = pending_reqs.pop_front();
        start <= 1'b1;
        req   <= p.req;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
        end else begin
          burst_left = burst_left - 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: record accepted requests, check each result against the oldest
  // expectation
  // ---------------------------------------------------------------------

  always @(posedge clk_i) begin : monitor
    dd_rsp_t want;
    if (rst_ni) begin
      if (done) begin
        if (expected_diffs.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= ShowLimit)
            $display("unexpected result: day_difference=%0d date_error=%b",
                     rsp.day_difference, rsp.date_error);
        end else begin
          want = expected_diffs.pop_front();
          if (rsp.day_difference !== want.day_difference || rsp.date_error !== want.date_error) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= ShowLimit)
              $display("mismatch: expected day_difference=%0d date_error=%b, got %0d %b",
                       want.day_difference, want.date_error,
                       rsp.day_difference, rsp.date_error);
          end
        end
      end
      if (start && !busy) expected_diffs.push_back(days_between(req));
    end
  end

  // Stop a run that hangs
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------

  initial begin
    // Span of the valid calendar, both directions
    add_request(1, 1, 1, 9999, 12, 31, 1'b0);
    add_request(9999, 12, 31, 1, 1, 1, 1'b1);
    // Equal dates, without and with the end day
    add_request(2024, 2, 29, 2024, 2, 29, 1'b0);
    add_request(2024, 2, 29, 2024, 2, 29, 1'b1);
    // Leap day in a year divisible by 400, none in a plain century year
    add_request(2000, 2, 28, 2000, 3, 1, 1'b0);
    add_request(1900, 2, 28, 1900, 3, 1, 1'b0);
    add_request(2023, 12, 31, 2024, 1, 1, 1'b1);
    // Invalid dates: missing leap day, month codes out of range, bad days
    add_request(1900, 2, 29, 1901, 1, 1, 1'b0);
    add_request(2020, 5, 5, 2021, 0, 10, 1'b0);
    add_request(2020, 13, 1, 2021, 1, 10, 1'b1);
    add_request(2020, 1, 1, 2021, 15, 31, 1'b0);
    add_request(2020, 6, 0, 2021, 1, 10, 1'b0);
    add_request(2020, 6, 1, 2021, 4, 31, 1'b1);
    add_request(0, 0, 0, 0, 0, 0, 1'b0);
    add_request(16383, 15, 31, 16383, 15, 31, 1'b1);
    // Year zero is a leap year
    add_request(0, 2, 29, 1, 1, 1, 1'b0);
    // Largest years: saturate the magnitude in both directions, then a small step at the top
    add_request(0, 1, 1, 16383, 12, 31, 1'b1);
    add_request(16383, 12, 31, 0, 1, 1, 1'b0);
    add_request(16383, 12, 31, 16383, 12, 30, 1'b0);
    add_drain();

    for (int unsigned i = 0; i < RandomReqs; i++) begin
      add_random_request();
      if (i % DrainEvery == DrainEvery - 1) add_drain();
    end

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the last request to go in and the last result to come out,
    // then give stray results a chance to show up.
    while (pending_reqs.size() != 0 || start || expected_diffs.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (mismatch_count == 0 && expected_diffs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/dd_pkg.sv
hw/rtl/dd_lane.sv
hw/rtl/dd_merge.sv
hw/rtl/date_difference_days.sv
hw/rtl/dd_checker.sv
tb/testbench.sv
